FILE: sv/wgop_pkg.sv
// ----------------------------------------------------------------------------
// wgop_pkg
// Shared types, register map and image tables for the wallpaper group orbit
// point generator.
// ----------------------------------------------------------------------------
package wgop_pkg;

  // Largest tile side accepted by the tile_size register
  localparam int MAX_TILE = 4096;

  // Field widths
  localparam int POS_W   = 12;
  localparam int IMG_W   = 14;
  localparam int GRP_W   = 5;
  localparam int TILE_W  = 13;
  localparam int HALF_W  = 12;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  localparam int NUM_GROUPS = 17;
  localparam int NUM_IMAGES = 78;
  localparam int IDX_W      = 7;   // index into the image table
  localparam int CNT_W      = 4;   // image count per group, up to 12

  // Register index, paddr[3:2]
  typedef enum logic [1:0] {
    REG_GROUP = 2'd0,
    REG_TILE  = 2'd1,
    REG_HALF  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  // Group codes in table order
  typedef enum logic [GRP_W-1:0] {
    GRP_CM   = 5'd0,
    GRP_CMM  = 5'd1,
    GRP_P1   = 5'd2,
    GRP_P2   = 5'd3,
    GRP_P3   = 5'd4,
    GRP_P31M = 5'd5,
    GRP_P3M1 = 5'd6,
    GRP_P4   = 5'd7,
    GRP_P4G  = 5'd8,
    GRP_P4M  = 5'd9,
    GRP_P6   = 5'd10,
    GRP_P6M  = 5'd11,
    GRP_PG   = 5'd12,
    GRP_PGG  = 5'd13,
    GRP_PM   = 5'd14,
    GRP_PMG  = 5'd15,
    GRP_PMM  = 5'd16
  } group_t;

  // One coordinate of an image as a combination of x, y, s and h
  typedef enum logic [3:0] {
    CX   = 4'd0,  // x
    CY   = 4'd1,  // y
    CSX  = 4'd2,  // s - x
    CSY  = 4'd3,  // s - y
    CSXY = 4'd4,  // s - x - y
    CXY  = 4'd5,  // x + y
    CHX  = 4'd6,  // h - x
    CHY  = 4'd7,  // h - y
    CXH  = 4'd8,  // x + h
    CYH  = 4'd9   // y + h
  } coord_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
  } img_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [GRP_W-1:0]  group;
    logic [TILE_W-1:0] tile;
    logic [HALF_W-1:0] half;
  } cfg_t;

  localparam img_t IMG_TAB [NUM_IMAGES] = '{
    // cm
    '{CX, CY}, '{CY, CX},
    // cmm
    '{CX, CY}, '{CY, CX}, '{CSY, CSX}, '{CSX, CSY},
    // p1
    '{CX, CY},
    // p2
    '{CX, CY}, '{CSX, CSY},
    // p3
    '{CX, CY}, '{CSXY, CX}, '{CY, CSXY},
    // p31m
    '{CX, CY}, '{CSXY, CX}, '{CY, CSXY}, '{CSY, CSX}, '{CSX, CXY}, '{CXY, CSY},
    // p3m1
    '{CX, CY}, '{CSXY, CX}, '{CY, CSXY}, '{CY, CX}, '{CX, CSXY}, '{CSXY, CY},
    // p4
    '{CX, CY}, '{CY, CSX}, '{CSX, CSY}, '{CSY, CX},
    // p4g
    '{CX, CY}, '{CY, CSX}, '{CSX, CSY}, '{CSY, CX},
    '{CHY, CHX}, '{CXH, CHY}, '{CYH, CXH}, '{CHX, CYH},
    // p4m
    '{CX, CY}, '{CSX, CY}, '{CX, CSY}, '{CSX, CSY},
    '{CY, CX}, '{CSY, CX}, '{CY, CSX}, '{CSY, CSX},
    // p6
    '{CX, CY}, '{CSXY, CX}, '{CY, CSXY}, '{CSX, CSY}, '{CXY, CSX}, '{CSY, CXY},
    // p6m
    '{CX, CY}, '{CSXY, CX}, '{CY, CSXY}, '{CSX, CSY}, '{CXY, CSX}, '{CSY, CXY},
    '{CY, CX}, '{CSXY, CY}, '{CX, CSXY}, '{CSY, CSX}, '{CXY, CSY}, '{CSX, CXY},
    // pg
    '{CX, CY}, '{CXH, CSY},
    // pgg
    '{CX, CY}, '{CSX, CYH}, '{CXH, CSY}, '{CHX, CHY},
    // pm
    '{CX, CY}, '{CSX, CY},
    // pmg
    '{CX, CY}, '{CSX, CY}, '{CXH, CSY}, '{CHX, CSY},
    // pmm
    '{CX, CY}, '{CSX, CY}, '{CX, CSY}, '{CSX, CSY}
  };

  localparam logic [IDX_W-1:0] GRP_START [NUM_GROUPS] = '{
    7'd0, 7'd2, 7'd6, 7'd7, 7'd9, 7'd12, 7'd18, 7'd24, 7'd28,
    7'd36, 7'd44, 7'd50, 7'd62, 7'd64, 7'd68, 7'd70, 7'd74
  };

  localparam logic [CNT_W-1:0] GRP_COUNT [NUM_GROUPS] = '{
    4'd2, 4'd4, 4'd1, 4'd2, 4'd3, 4'd6, 4'd6, 4'd4, 4'd8,
    4'd8, 4'd6, 4'd12, 4'd2, 4'd4, 4'd2, 4'd4, 4'd4
  };

endpackage

FILE: sv/wallpaper_group_orbit_points_core.sv
// ----------------------------------------------------------------------------
// wallpaper_group_orbit_points_core
// Emits every image of a tile point under the configured wallpaper group.
// ----------------------------------------------------------------------------
// Each accepted point produces 1 to 12 result requests (p1 gives one, p6m
// twelve), one per clock while out_stall is low, identity image first, with
// out_last on the final one. The point sits in the input register while an
// image counter walks the group's table and the output register takes one
// image per cycle unless out_stall holds it. The next point is taken in the
// same cycle the final image of the current one moves to the output register,
// so with out_stall low the stream is gapless. Coordinates are signed 14-bit
// values, wrapped modulo 2^14. Configuration must be written through the APB
// port only while no point is in flight; the block does not enforce this.
module wallpaper_group_orbit_points_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wgop_pkg::ADDR_W-1:0]        paddr,
  input  logic [wgop_pkg::DATA_W-1:0]        pwdata,
  output logic [wgop_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [wgop_pkg::POS_W-1:0]         in_pos_x,
  input  logic [wgop_pkg::POS_W-1:0]         in_pos_y,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [wgop_pkg::IMG_W-1:0]  out_image_x,
  output logic signed [wgop_pkg::IMG_W-1:0]  out_image_y,
  output logic                               out_last
);
  import wgop_pkg::*;

  cfg_t              cfg;
  logic              busy_r, busy_nxt;
  logic [POS_W-1:0]  x_r, y_r;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              ov_r, ov_nxt;
  logic signed [IMG_W-1:0] ox_r, oy_r;
  logic              ol_r;
  logic signed [IMG_W-1:0] img_x, img_y;
  logic              img_last;
  logic              adv, emit, take;

  wgop_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wgop_image u_image (
    .cfg     (cfg),
    .pos_x   (x_r),
    .pos_y   (y_r),
    .k       (k_r),
    .image_x (img_x),
    .image_y (img_y),
    .last    (img_last)
  );

  // handshake
  assign adv      = !ov_r || !out_stall;
  assign emit     = busy_r && adv;
  assign in_stall = busy_r && !(emit && img_last);
  assign take     = in_valid && !in_stall;

  // input register and image counter
  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (emit) begin
      k_nxt = k_r + CNT_W'(1);
      if (img_last) busy_nxt = 1'b0;
    end
    if (take) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end
  end

  // output register
  assign ov_nxt = adv ? emit : ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      x_r <= in_pos_x;
      y_r <= in_pos_y;
    end
    if (emit) begin
      ox_r <= img_x;
      oy_r <= img_y;
      ol_r <= img_last;
    end
  end

  assign out_valid   = ov_r;
  assign out_image_x = ox_r;
  assign out_image_y = oy_r;
  assign out_last    = ol_r;

endmodule

FILE: sv/wgop_cfg.sv
// ----------------------------------------------------------------------------
// wgop_cfg
// APB-style register bank: symmetry group, tile size and half size.
// ----------------------------------------------------------------------------
module wgop_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wgop_pkg::ADDR_W-1:0]  paddr,
  input  logic [wgop_pkg::DATA_W-1:0]  pwdata,
  output logic [wgop_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output wgop_pkg::cfg_t               cfg
);
  import wgop_pkg::*;

  logic [GRP_W-1:0]  group_r;
  logic [TILE_W-1:0] tile_r;
  logic [HALF_W-1:0] half_r;
  logic [TILE_W-1:0] tile_wr;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // tile writes above the maximum saturate
  assign tile_wr = (pwdata[TILE_W-1:0] > TILE_W'(MAX_TILE)) ? TILE_W'(MAX_TILE)
                                                            : pwdata[TILE_W-1:0];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= GRP_P1;
      tile_r  <= TILE_W'(256);
      half_r  <= HALF_W'(128);
    end else if (wr_en) begin
      unique case (idx)
        REG_GROUP: group_r <= pwdata[GRP_W-1:0];
        REG_TILE:  tile_r  <= tile_wr;
        REG_HALF:  half_r  <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_GROUP: prdata = DATA_W'(group_r);
      REG_TILE:  prdata = DATA_W'(tile_r);
      REG_HALF:  prdata = DATA_W'(half_r);
      default:   prdata = '0;
    endcase
  end

  assign cfg.group = group_r;
  assign cfg.tile  = tile_r;
  assign cfg.half  = half_r;

endmodule

FILE: sv/wgop_image.sv
// ----------------------------------------------------------------------------
// wgop_image
// Looks up image k of the selected group and evaluates both coordinates.
// ----------------------------------------------------------------------------
module wgop_image (
  input  wgop_pkg::cfg_t                    cfg,
  input  logic [wgop_pkg::POS_W-1:0]        pos_x,
  input  logic [wgop_pkg::POS_W-1:0]        pos_y,
  input  logic [wgop_pkg::CNT_W-1:0]        k,
  output logic signed [wgop_pkg::IMG_W-1:0] image_x,
  output logic signed [wgop_pkg::IMG_W-1:0] image_y,
  output logic                              last
);
  import wgop_pkg::*;

  logic [GRP_W-1:0] grp;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  img_t             img;
  logic [IMG_W-1:0] x, y, s, h;

  // evaluate one coordinate code, modulo 2^14
  function automatic logic [IMG_W-1:0] eval_coord(
    input coord_t c, input logic [IMG_W-1:0] vx, input logic [IMG_W-1:0] vy,
    input logic [IMG_W-1:0] vs, input logic [IMG_W-1:0] vh);
    logic [IMG_W-1:0] r;
    case (c)
      CX:      r = vx;
      CY:      r = vy;
      CSX:     r = vs - vx;
      CSY:     r = vs - vy;
      CSXY:    r = vs - vx - vy;
      CXY:     r = vx + vy;
      CHX:     r = vh - vx;
      CHY:     r = vh - vy;
      CXH:     r = vx + vh;
      CYH:     r = vy + vh;
      default: r = vx;
    endcase
    return r;
  endfunction

  // unused group codes fall back to p1
  assign grp = (cfg.group < GRP_W'(NUM_GROUPS)) ? cfg.group : GRP_P1;
  assign cnt = GRP_COUNT[grp];
  assign idx = GRP_START[grp] + IDX_W'(k);
  assign img = IMG_TAB[idx];

  assign x = IMG_W'(pos_x);
  assign y = IMG_W'(pos_y);
  assign s = IMG_W'(cfg.tile);
  assign h = IMG_W'(cfg.half);

  assign image_x = $signed(eval_coord(img.cx, x, y, s, h));
  assign image_y = $signed(eval_coord(img.cy, x, y, s, h));
  assign last    = (k == cnt - CNT_W'(1));

endmodule

FILE: verif/wallpaper_group_orbit_points_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wallpaper_group_orbit_points_core_test
// Self-checking bench for the wallpaper group orbit point generator.
// ----------------------------------------------------------------------------
// Walks a directed table of register writes and tile points. The table covers
// every group, the coordinate extremes, tile saturation, zero tile and the
// spare group codes. It then runs random phases, each with a fresh register
// setting. Every image request is checked against a typed expectation or a
// local orbit calculation that runs on shadow copies of the registers. Both
// channels idle at random, with one phase kept free of idling.
// ----------------------------------------------------------------------------
module wallpaper_group_orbit_points_core_test;
  import wgop_pkg::*;

  // spare group codes, which behave as p1
  localparam int GRP_SPARE_FIRST = 17;
  localparam int GRP_SPARE_LAST  = 31;
  localparam int NUM_ROWS        = 51;
  localparam int NUM_PHASES      = 12;
  localparam int PHASE_POINTS    = 18;

  typedef struct {
    logic signed [IMG_W-1:0] img_x;
    logic signed [IMG_W-1:0] img_y;
    logic                    last;
  } image_rec_t;

  typedef enum {ROW_WRITE, ROW_POINT} row_kind_t;

  typedef struct {
    row_kind_t kind;
    reg_idx_t  reg_sel;
    int        wval;
    int        px;
    int        py;
    bit        typed;
    int        tx;
    int        ty;
  } step_row_t;

  // Image recipes per group, identity first
  localparam img_t ORBIT_TAB [NUM_IMAGES] = '{
    '{CX, CY}, '{CY, CX},
    '{CX, CY}, '{CY, CX}, '{CSY, CSX}, '{CSX, CSY},
    '{CX, CY},
    '{CX, CY}, '{CSX, CSY},
    '{CX, CY}, '{CSXY, CX}, '{CY, CSXY},
    '{CX, CY}, '{CSXY, CX}, '{CY, CSXY}, '{CSY, CSX}, '{CSX, CXY}, '{CXY, CSY},
    '{CX, CY}, '{CSXY, CX}, '{CY, CSXY}, '{CY, CX}, '{CX, CSXY}, '{CSXY, CY},
    '{CX, CY}, '{CY, CSX}, '{CSX, CSY}, '{CSY, CX},
    '{CX, CY}, '{CY, CSX}, '{CSX, CSY}, '{CSY, CX},
    '{CHY, CHX}, '{CXH, CHY}, '{CYH, CXH}, '{CHX, CYH},
    '{CX, CY}, '{CSX, CY}, '{CX, CSY}, '{CSX, CSY},
    '{CY, CX}, '{CSY, CX}, '{CY, CSX}, '{CSY, CSX},
    '{CX, CY}, '{CSXY, CX}, '{CY, CSXY}, '{CSX, CSY}, '{CXY, CSX}, '{CSY, CXY},
    '{CX, CY}, '{CSXY, CX}, '{CY, CSXY}, '{CSX, CSY}, '{CXY, CSX}, '{CSY, CXY},
    '{CY, CX}, '{CSXY, CY}, '{CX, CSXY}, '{CSY, CSX}, '{CXY, CSY}, '{CSX, CXY},
    '{CX, CY}, '{CXH, CSY},
    '{CX, CY}, '{CSX, CYH}, '{CXH, CSY}, '{CHX, CHY},
    '{CX, CY}, '{CSX, CY},
    '{CX, CY}, '{CSX, CY}, '{CXH, CSY}, '{CHX, CSY},
    '{CX, CY}, '{CSX, CY}, '{CX, CSY}, '{CSX, CSY}
  };

  localparam int ORBIT_COUNT [NUM_GROUPS] = '{
    2, 4, 1, 2, 3, 6, 6, 4, 8, 8, 6, 12, 2, 4, 2, 4, 4
  };

  // Directed table: a typed expectation means a single image with last set
  step_row_t plan [NUM_ROWS] = '{
    '{ROW_POINT, REG_NONE,  0,               0,    0,    1'b1, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 4095, 1'b1, 4095, 4095},
    '{ROW_POINT, REG_NONE,  0,               2730, 1365, 1'b1, 2730, 1365},
    '{ROW_WRITE, REG_TILE,  4096,            0,    0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_HALF,  2048,            0,    0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_CM,          0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_CMM,         0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               1,    2,    1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P2,          0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 4095, 1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P3,          0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               0,    0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P31M,        0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 4095, 1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P3M1,        0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               100,  200,  1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P4,          0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P4G,         0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               0,    4095, 1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P4M,         0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               3000, 17,   1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P6,          0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 4095, 1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P6M,         0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 4095, 1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_PG,          0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               0,    0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_PGG,         0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 4095, 1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_PM,          0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               2048, 2048, 1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_PMG,         0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               0,    4095, 1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_PMM,         0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               12,   4000, 1'b0, 0,    0},
    '{ROW_WRITE, REG_TILE,  8191,            0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               0,    0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_TILE,  0,               0,    0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_HALF,  4095,            0,    0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P6M,         0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_SPARE_LAST,  0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               7,    9,    1'b1, 7,    9},
    '{ROW_WRITE, REG_GROUP, GRP_SPARE_FIRST, 0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 1,    1'b1, 4095, 1},
    '{ROW_WRITE, REG_TILE,  1,               0,    0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_HALF,  0,               0,    0,    1'b0, 0,    0},
    '{ROW_WRITE, REG_GROUP, GRP_P4G,         0,    0,    1'b0, 0,    0},
    '{ROW_POINT, REG_NONE,  0,               4095, 4095, 1'b0, 0,    0}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid;
  logic                    in_stall;
  logic [POS_W-1:0]        in_pos_x;
  logic [POS_W-1:0]        in_pos_y;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [IMG_W-1:0] out_image_x;
  logic signed [IMG_W-1:0] out_image_y;
  logic                    out_last;

  // shadow registers and images still owed by the block
  logic [GRP_W-1:0]  shadow_group;
  logic [TILE_W-1:0] shadow_tile;
  logic [HALF_W-1:0] shadow_half;
  image_rec_t        due_images [$];
  int                error_count = 0;
  bit                steady = 1'b0;   // no idling on either side

  wallpaper_group_orbit_points_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_image_x (out_image_x),
    .out_image_y (out_image_y),
    .out_last    (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // One coordinate of an image, wrapped to the output width
  function automatic logic signed [IMG_W-1:0] coord_value(input coord_t c, input int px,
                                                          input int py, input int s,
                                                          input int h);
    int v;
    case (c)
      CX:      v = px;
      CY:      v = py;
      CSX:     v = s - px;
      CSY:     v = s - py;
      CSXY:    v = s - px - py;
      CXY:     v = px + py;
      CHX:     v = h - px;
      CHY:     v = h - py;
      CXH:     v = px + h;
      CYH:     v = py + h;
      default: v = 0;
    endcase
    return v[IMG_W-1:0];
  endfunction

  // Append one owed image at the tail of the queue
  function automatic void owe_image(input image_rec_t rec);
    due_images.insert(due_images.size(), rec);
  endfunction

  // Queue every image of a point under the current shadow setting
  function automatic void compute_orbit(input int px, input int py);
    int         grp;
    int         first;
    int         k;
    image_rec_t img;
    grp = (shadow_group < NUM_GROUPS) ? int'(shadow_group) : int'(GRP_P1);
    first = 0;
    for (k = 0; k < grp; k++) first += ORBIT_COUNT[k];
    for (k = 0; k < ORBIT_COUNT[grp]; k++) begin
      img.img_x = coord_value(ORBIT_TAB[first+k].cx, px, py, shadow_tile, shadow_half);
      img.img_y = coord_value(ORBIT_TAB[first+k].cy, px, py, shadow_tile, shadow_half);
      img.last  = (k == ORBIT_COUNT[grp] - 1);
      owe_image(img);
    end
  endfunction

  // Drop valid and let the block drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_images.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register
  task automatic cfg_write(input reg_idx_t sel, input logic [DATA_W-1:0] wdata);
    logic [DATA_W-1:0] held;
    case (sel)
      REG_GROUP: shadow_group = wdata[GRP_W-1:0];
      REG_TILE:  shadow_tile  = (wdata[TILE_W-1:0] > MAX_TILE) ? TILE_W'(MAX_TILE)
                                                                : wdata[TILE_W-1:0];
      REG_HALF:  shadow_half  = wdata[HALF_W-1:0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (sel)
      REG_GROUP: held = DATA_W'(shadow_group);
      REG_TILE:  held = DATA_W'(shadow_tile);
      REG_HALF:  held = DATA_W'(shadow_half);
      default:   held = '0;
    endcase
    if (prdata !== held) begin
      $error("prdata: expected %0d, got %0d", held, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    // bus returns to idle before the next transfer
    @(posedge clk);
  endtask

  // Present one point and hold it until the block takes it
  task automatic drive_point(input int px, input int py);
    int gap;
    gap = (!steady && $urandom_range(99) < 20) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px[POS_W-1:0];
    in_pos_y <= py[POS_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result checker and random back-pressure
  always @(posedge clk) begin : result_check
    image_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_images.size() == 0) begin
        $error("unexpected image request x=%0d y=%0d", out_image_x, out_image_y);
        error_count++;
      end else begin
        want = due_images.pop_front();
        if (out_image_x !== want.img_x) begin
          $error("image_x: expected %0d, got %0d", want.img_x, out_image_x);
          error_count++;
        end
        if (out_image_y !== want.img_y) begin
          $error("image_y: expected %0d, got %0d", want.img_y, out_image_y);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          error_count++;
        end
      end
    end
    out_stall <= !steady && ($urandom_range(99) < 20);
  end

  initial begin : stimulus
    int                i;
    int                p;
    int                px;
    int                py;
    int                sel_val;
    image_rec_t        img;
    logic [DATA_W-1:0] wdata;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    in_pos_x     = '0;
    in_pos_y     = '0;
    shadow_group = GRP_P1;
    shadow_tile  = 13'd256;
    shadow_half  = 12'd128;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (i = 0; i < NUM_ROWS; i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(plan[i].reg_sel, DATA_W'(plan[i].wval));
      end else begin
        if (plan[i].typed) begin
          img.img_x = plan[i].tx;
          img.img_y = plan[i].ty;
          img.last  = 1'b1;
          owe_image(img);
        end else begin
          compute_orbit(plan[i].px, plan[i].py);
        end
        drive_point(plan[i].px, plan[i].py);
      end
    end

    // random phases, each with its own register setting
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      steady = (p == 4);
      sel_val = ($urandom_range(9) == 0) ? $urandom_range(GRP_SPARE_FIRST, GRP_SPARE_LAST)
                                         : $urandom_range(0, NUM_GROUPS - 1);
      wdata = ($urandom << GRP_W) | DATA_W'(sel_val);
      cfg_write(REG_GROUP, wdata);
      case ($urandom_range(5))
        0:       sel_val = 0;
        1:       sel_val = MAX_TILE;
        2:       sel_val = $urandom_range(MAX_TILE + 1, 8191);
        default: sel_val = $urandom_range(1, MAX_TILE);
      endcase
      wdata = ($urandom << TILE_W) | DATA_W'(sel_val);
      cfg_write(REG_TILE, wdata);
      case ($urandom_range(4))
        0:       sel_val = 0;
        1:       sel_val = 4095;
        default: sel_val = $urandom_range(0, 2048);
      endcase
      wdata = ($urandom << HALF_W) | DATA_W'(sel_val);
      cfg_write(REG_HALF, wdata);
      for (i = 0; i < PHASE_POINTS; i++) begin
        // one mid-phase pause until the block has drained
        if (p == 7 && i == 9) wait_idle();
        px = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 4095 : 0) : $urandom_range(4095);
        py = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 4095 : 0) : $urandom_range(4095);
        compute_orbit(px, py);
        drive_point(px, py);
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
